// ===== sv/eabf_pkg.sv =====
package eabf_pkg;

    // Widths fixed by the block's fields
    localparam int INDEX_BITS      = 16;
    localparam int CFG_INDEX_W     = 8;
    localparam int MAX_EXTENTS_DEF = 16;

    typedef logic [INDEX_BITS-1:0]  t_idx;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [1:0]             t_status;

    // Result codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NOFIT = 2'd1;
    localparam t_status ST_ZERO  = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam t_cfg_index CFG_POOL_BASE  = 8'd0;
    localparam t_cfg_index CFG_POOL_COUNT = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DROP_A,
        S_DROP_B,
        S_PLACE,
        S_INSERT,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic drop_a;
        logic drop_b;
        logic place;
        logic insert;
        logic emit;
        logic cfg_wr;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fail;
        logic drop_b_en;
        logic new_zero;
    } t_stat;

endpackage

// ===== sv/eabf_ctrl.sv =====
module eabf_ctrl #(
    parameter int MAX_EXTENTS = eabf_pkg::MAX_EXTENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  eabf_pkg::t_stat                i_stat,
    output eabf_pkg::t_cmd                 o_cmd,
    output logic [$clog2(MAX_EXTENTS)-1:0] o_step
);

    localparam int PW = $clog2(MAX_EXTENTS);
    localparam logic [PW-1:0] LAST_STEP = PW'(MAX_EXTENTS - 1);

    eabf_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_step, n_step;
    logic             r_out_valid, n_out_valid;

    // State, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= eabf_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.cfg_wr = i_cfg_valid && !i_in_valid && (r_state == eabf_pkg::S_IDLE);
        unique case (r_state)
            eabf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = eabf_pkg::S_SCAN;
                end
            end
            eabf_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = eabf_pkg::S_DECIDE;
                end
            end
            eabf_pkg::S_DECIDE: begin
                o_cmd.commit = 1'b1;
                n_state      = eabf_pkg::S_DROP_A;
            end
            eabf_pkg::S_DROP_A: begin
                o_cmd.drop_a = 1'b1;
                priority if (i_stat.fail) begin
                    n_state = eabf_pkg::S_FINISH;
                end else if (i_stat.drop_b_en) begin
                    n_state = eabf_pkg::S_DROP_B;
                end else if (i_stat.new_zero) begin
                    n_state = eabf_pkg::S_FINISH;
                end else begin
                    n_state = eabf_pkg::S_PLACE;
                end
            end
            eabf_pkg::S_DROP_B: begin
                o_cmd.drop_b = 1'b1;
                n_state      = i_stat.new_zero ? eabf_pkg::S_FINISH : eabf_pkg::S_PLACE;
            end
            eabf_pkg::S_PLACE: begin
                o_cmd.place = 1'b1;
                n_step      = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = eabf_pkg::S_INSERT;
                end
            end
            eabf_pkg::S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = eabf_pkg::S_FINISH;
            end
            eabf_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = eabf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = eabf_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        priority if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // A request offered in the same cycle goes ahead of a configuration write
    assign o_in_stall  = (r_state != eabf_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == eabf_pkg::S_IDLE) && !i_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_step      = r_step;

`ifndef SYNTH
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eabf_pkg::S_SCAN && r_step == LAST_STEP) |=> r_state == eabf_pkg::S_DECIDE)
        else $error("scan pass did not end in decide");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted result not presented");
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== sv/eabf_dp.sv =====
module eabf_dp #(
    parameter int MAX_EXTENTS = eabf_pkg::MAX_EXTENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  eabf_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(MAX_EXTENTS)-1:0] i_step,
    output eabf_pkg::t_stat                o_stat,
    input  logic                           i_opcode,
    input  eabf_pkg::t_idx                 i_run_length,
    input  eabf_pkg::t_idx                 i_run_start,
    input  eabf_pkg::t_cfg_index           i_cfg_index,
    input  eabf_pkg::t_idx                 i_cfg_data,
    output eabf_pkg::t_status              o_status,
    output eabf_pkg::t_idx                 o_granted_start,
    output eabf_pkg::t_idx                 o_free_blocks
);

    localparam int W  = eabf_pkg::INDEX_BITS;
    localparam int PW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_EXTENTS);
    localparam logic [W-1:0]  IDX_MAX  = '1;

    // Extent table, ordered by ascending length
    logic [W-1:0]  r_start [MAX_EXTENTS];
    logic [W-1:0]  r_len   [MAX_EXTENTS];
    logic [W-1:0]  n_start [MAX_EXTENTS];
    logic [W-1:0]  n_len   [MAX_EXTENTS];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_total, n_total;
    logic [W-1:0]  r_base, n_base;
    logic [W-1:0]  r_count, n_count;

    // Request
    logic          r_op;
    logic [W-1:0]  r_rlen, r_rstart;

    // Scan findings
    logic          r_fit_found, r_lo_found, r_hi_found;
    logic [PW-1:0] r_fit_idx, r_lo_idx, r_hi_idx;
    logic [W-1:0]  r_fit_s, r_fit_l, r_lo_s, r_lo_l, r_hi_l;

    // Decided action
    logic          r_fail, r_drop_a_en, r_drop_b_en, r_new_zero;
    logic [PW-1:0] r_drop_a_idx, r_drop_b_idx;
    logic [W-1:0]  r_new_s, r_new_l;
    logic [CW-1:0] r_place;
    eabf_pkg::t_status r_res_status;
    logic [W-1:0]  r_res_granted;

    // Output beat
    eabf_pkg::t_status r_out_status;
    logic [W-1:0]  r_out_granted, r_out_free;

    logic          head_valid;
    logic [W:0]    head_end, run_end;
    logic          cfg_hit;
    logic          drop_now;
    logic [PW-1:0] drop_idx;

    logic              c_zero;
    eabf_pkg::t_status c_status;
    logic [W+1:0]      c_sum;
    logic [W-1:0]      c_new_s, c_new_l, c_total, c_granted;
    logic [W:0]        c_total_sum;
    logic              c_both;
    logic [PW-1:0]     c_drop_a_idx, c_drop_b_idx;
    logic              c_drop_a_en;

    assign head_valid = (CW'(i_step) < r_cnt);
    assign head_end   = {1'b0, r_start[0]} + {1'b0, r_len[0]};
    assign run_end    = {1'b0, r_rstart} + {1'b0, r_rlen};

    assign cfg_hit  = i_cmd.cfg_wr && (i_cfg_index == eabf_pkg::CFG_POOL_BASE ||
                                       i_cfg_index == eabf_pkg::CFG_POOL_COUNT);
    assign n_base   = (i_cmd.cfg_wr && i_cfg_index == eabf_pkg::CFG_POOL_BASE)
                      ? i_cfg_data : r_base;
    assign n_count  = (i_cmd.cfg_wr && i_cfg_index == eabf_pkg::CFG_POOL_COUNT)
                      ? i_cfg_data : r_count;
    assign drop_now = (i_cmd.drop_a && r_drop_a_en && !r_fail) ||
                      (i_cmd.drop_b && r_drop_b_en);
    assign drop_idx = i_cmd.drop_a ? r_drop_a_idx : r_drop_b_idx;

    // Decide the outcome from the scan findings
    always_comb begin
        c_zero      = (r_rlen == '0);
        c_both      = r_lo_found && r_hi_found;
        c_sum       = {2'b00, r_rlen} + (r_lo_found ? {2'b00, r_lo_l} : '0)
                      + (r_hi_found ? {2'b00, r_hi_l} : '0);
        c_total_sum = {1'b0, r_total} + {1'b0, r_rlen};
        c_granted   = '0;
        priority if (c_zero) begin
            c_status = eabf_pkg::ST_ZERO;
        end else if (r_op == eabf_pkg::OP_ALLOC) begin
            c_status = r_fit_found ? eabf_pkg::ST_OK : eabf_pkg::ST_NOFIT;
        end else if (!r_lo_found && !r_hi_found && r_cnt == FULL_CNT) begin
            c_status = eabf_pkg::ST_FULL;
        end else begin
            c_status = eabf_pkg::ST_OK;
        end
        if (r_op == eabf_pkg::OP_ALLOC) begin
            c_new_s      = r_fit_s + r_rlen;
            c_new_l      = r_fit_l - r_rlen;
            c_total      = (r_total >= r_rlen) ? (r_total - r_rlen) : '0;
            c_drop_a_idx = r_fit_idx;
            c_drop_b_idx = r_fit_idx;
            c_drop_a_en  = 1'b1;
            if (c_status == eabf_pkg::ST_OK) begin
                c_granted = r_fit_s;
            end
        end else begin
            c_new_s      = r_lo_found ? r_lo_s : r_rstart;
            c_new_l      = (c_sum > {2'b00, IDX_MAX}) ? IDX_MAX : c_sum[W-1:0];
            c_total      = c_total_sum[W] ? IDX_MAX : c_total_sum[W-1:0];
            c_drop_a_en  = r_lo_found || r_hi_found;
            // Remove the later slot first so the earlier index stays put
            if (c_both) begin
                c_drop_a_idx = (r_lo_idx > r_hi_idx) ? r_lo_idx : r_hi_idx;
                c_drop_b_idx = (r_lo_idx > r_hi_idx) ? r_hi_idx : r_lo_idx;
            end else begin
                c_drop_a_idx = r_lo_found ? r_lo_idx : r_hi_idx;
                c_drop_b_idx = r_lo_idx;
            end
        end
    end

    // Table next value: rebuild, rotate, drop or insert
    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_cnt   = r_cnt;
        priority if (cfg_hit) begin
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                n_len[i] = '0;
            end
            n_start[0] = n_base;
            n_len[0]   = n_count;
            n_cnt      = (n_count != '0) ? CW'(1) : '0;
        end else if (i_cmd.scan || i_cmd.place) begin
            for (int i = 0; i < MAX_EXTENTS - 1; i++) begin
                n_start[i] = r_start[i+1];
                n_len[i]   = r_len[i+1];
            end
            n_start[MAX_EXTENTS-1] = r_start[0];
            n_len[MAX_EXTENTS-1]   = r_len[0];
        end else if (drop_now) begin
            for (int i = 0; i < MAX_EXTENTS - 1; i++) begin
                if (PW'(i) >= drop_idx) begin
                    n_start[i] = r_start[i+1];
                    n_len[i]   = r_len[i+1];
                end
            end
            n_len[MAX_EXTENTS-1] = '0;
            n_cnt = r_cnt - 1'b1;
        end else if (i_cmd.insert) begin
            for (int i = 1; i < MAX_EXTENTS; i++) begin
                if (CW'(i) > r_place) begin
                    n_start[i] = r_start[i-1];
                    n_len[i]   = r_len[i-1];
                end
            end
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                if (CW'(i) == r_place) begin
                    n_start[i] = r_new_s;
                    n_len[i]   = r_new_l;
                end
            end
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // Free total
    always_comb begin
        priority if (cfg_hit) begin
            n_total = n_count;
        end else if (i_cmd.commit && c_status == eabf_pkg::ST_OK) begin
            n_total = c_total;
        end else begin
            n_total = r_total;
        end
    end

    // Control-bearing table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                r_len[i] <= '0;
            end
            r_cnt   <= '0;
            r_total <= '0;
            r_base  <= W'(1);
            r_count <= '0;
        end else begin
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

    // Extent starts
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

    // Request, scan, decision and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_found  <= 1'b0;
            r_lo_found   <= 1'b0;
            r_hi_found   <= 1'b0;
            r_fail       <= 1'b1;
            r_drop_a_en  <= 1'b0;
            r_drop_b_en  <= 1'b0;
            r_new_zero   <= 1'b1;
            r_place      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op        <= i_opcode;
                r_rlen      <= i_run_length;
                r_rstart    <= i_run_start;
                r_fit_found <= 1'b0;
                r_lo_found  <= 1'b0;
                r_hi_found  <= 1'b0;
            end
            // Record the first matching slot of each kind
            if (i_cmd.scan && head_valid) begin
                if (!r_fit_found && r_len[0] >= r_rlen) begin
                    r_fit_found <= 1'b1;
                    r_fit_idx   <= i_step;
                    r_fit_s     <= r_start[0];
                    r_fit_l     <= r_len[0];
                end
                if (!r_lo_found && head_end == {1'b0, r_rstart}) begin
                    r_lo_found <= 1'b1;
                    r_lo_idx   <= i_step;
                    r_lo_s     <= r_start[0];
                    r_lo_l     <= r_len[0];
                end
                if (!r_hi_found && {1'b0, r_start[0]} == run_end) begin
                    r_hi_found <= 1'b1;
                    r_hi_idx   <= i_step;
                    r_hi_l     <= r_len[0];
                end
            end
            if (i_cmd.commit) begin
                r_fail        <= (c_status != eabf_pkg::ST_OK);
                r_drop_a_en   <= c_drop_a_en;
                r_drop_b_en   <= c_both && (c_status == eabf_pkg::ST_OK) &&
                                 (r_op == eabf_pkg::OP_FREE);
                r_drop_a_idx  <= c_drop_a_idx;
                r_drop_b_idx  <= c_drop_b_idx;
                r_new_s       <= c_new_s;
                r_new_l       <= c_new_l;
                r_new_zero    <= (c_new_l == '0);
                r_res_status  <= c_status;
                r_res_granted <= c_granted;
                r_place       <= '0;
            end
            // Count live slots shorter than the new extent
            if (i_cmd.place && head_valid && r_len[0] < r_new_l) begin
                r_place <= r_place + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_status  <= r_res_status;
                r_out_granted <= r_res_granted;
                r_out_free    <= r_total;
            end
        end
    end

    assign o_stat.fail      = r_fail;
    assign o_stat.drop_b_en = r_drop_b_en;
    assign o_stat.new_zero  = r_new_zero;

    assign o_status        = r_out_status;
    assign o_granted_start = r_out_granted;
    assign o_free_blocks   = r_out_free;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("extent count beyond table size");
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> r_cnt < FULL_CNT)
        else $error("insert into a full table");
    a_drop_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drop_now |-> (CW'(drop_idx) < r_cnt))
        else $error("drop of an unused slot");
`endif

endmodule

// ===== sv/extent_allocator_best_fit_coalesce.sv =====
// Best-fit extent allocator with coalescing. One request is taken at a time:
// an allocate returns the start of the smallest free extent that covers the
// run, a free merges the run with its neighbours and puts the union back.
// The extent table is a row of MAX_EXTENTS registers that rotates past one
// compare stage, so each request costs one full scan pass to find the fit or
// the neighbours and, when an extent goes back, a second pass to find its
// sorted place. The result beat is held in an output register. A
// configuration write to the pool base or block count rebuilds the table and
// is taken only while no request is in flight.
module extent_allocator_best_fit_coalesce #(
    parameter int MAX_EXTENTS = eabf_pkg::MAX_EXTENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  eabf_pkg::t_idx        i_run_length,
    input  eabf_pkg::t_idx        i_run_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output eabf_pkg::t_status     o_status,
    output eabf_pkg::t_idx        o_granted_start,
    output eabf_pkg::t_idx        o_free_blocks,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  eabf_pkg::t_cfg_index  i_cfg_index,
    input  eabf_pkg::t_idx        i_cfg_data
);

    eabf_pkg::t_cmd                 cmd;
    eabf_pkg::t_stat                stat;
    logic [$clog2(MAX_EXTENTS)-1:0] step;

    eabf_ctrl #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_step      (step)
    );

    eabf_dp #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_step          (step),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_run_length    (i_run_length),
        .i_run_start     (i_run_start),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_status        (o_status),
        .o_granted_start (o_granted_start),
        .o_free_blocks   (o_free_blocks)
    );

endmodule

// ===== tb/extent_allocator_best_fit_coalesce_tb.sv =====
`timescale 1ns / 1ps

module extent_allocator_best_fit_coalesce_tb;

    localparam int NEXT = eabf_pkg::MAX_EXTENTS_DEF;
    localparam int LIMIT = 1000000;

    // Expected result of one request
    typedef struct {
        eabf_pkg::t_status st;
        eabf_pkg::t_idx    granted;
        eabf_pkg::t_idx    free_cnt;
    } t_alloc_res;

    // Free-extent table mirror and result queue
    class extent_scoreboard;
        eabf_pkg::t_idx ext_start[NEXT];
        eabf_pkg::t_idx ext_len[NEXT];
        int             used;
        eabf_pkg::t_idx total;
        eabf_pkg::t_idx base;
        eabf_pkg::t_idx count;
        t_alloc_res     pending[$];
        int             errors;

        function void clear_all();
            used = 0;
            total = '0;
            base = 16'd1;
            count = '0;
            errors = 0;
            for (int i = 0; i < NEXT; i++) begin
                ext_start[i] = '0;
                ext_len[i] = '0;
            end
        endfunction

        function void remove_at(int pos);
            if (pos >= used) return;
            for (int i = pos; i + 1 < used; i++) begin
                ext_start[i] = ext_start[i+1];
                ext_len[i] = ext_len[i+1];
            end
            used--;
            ext_start[used] = '0;
            ext_len[used] = '0;
        endfunction

        // Keep ascending length, newest first among equals
        function void insert_sorted(eabf_pkg::t_idx s, eabf_pkg::t_idx l);
            int pos;
            pos = 0;
            if (l == 0 || used >= NEXT) return;
            while (pos < used && ext_len[pos] < l) pos++;
            for (int i = used; i > pos; i--) begin
                ext_start[i] = ext_start[i-1];
                ext_len[i] = ext_len[i-1];
            end
            ext_start[pos] = s;
            ext_len[pos] = l;
            used++;
        endfunction

        function void write_reg(eabf_pkg::t_cfg_index idx, eabf_pkg::t_idx val);
            if (idx == eabf_pkg::CFG_POOL_BASE) base = val;
            else count = val;
            for (int i = 0; i < NEXT; i++) begin
                ext_start[i] = '0;
                ext_len[i] = '0;
            end
            used = 0;
            total = count;
            insert_sorted(base, count);
        endfunction

        function void note_request(logic op, eabf_pkg::t_idx len, eabf_pkg::t_idx start);
            t_alloc_res r;
            int pos, lo, hi;
            logic [16:0] run_end, sum;
            logic [17:0] nl;
            eabf_pkg::t_idx s, ns;
            r.st = eabf_pkg::ST_OK;
            r.granted = '0;
            if (len == 0) begin
                r.st = eabf_pkg::ST_ZERO;
            end else if (op == eabf_pkg::OP_ALLOC) begin
                pos = used;
                for (int i = 0; i < used; i++)
                    if (ext_len[i] >= len) begin pos = i; break; end
                if (pos >= used) begin
                    r.st = eabf_pkg::ST_NOFIT;
                end else begin
                    s = ext_start[pos];
                    nl = {2'b00, ext_len[pos]} - {2'b00, len};
                    r.granted = s;
                    remove_at(pos);
                    insert_sorted(s + len, nl[15:0]);
                    total = (total >= len) ? total - len : '0;
                end
            end else begin
                run_end = {1'b0, start} + {1'b0, len};
                lo = NEXT;
                hi = NEXT;
                for (int i = 0; i < used; i++) begin
                    sum = {1'b0, ext_start[i]} + {1'b0, ext_len[i]};
                    if (lo == NEXT && sum == {1'b0, start}) lo = i;
                    if (hi == NEXT && {1'b0, ext_start[i]} == run_end) hi = i;
                end
                if (lo == NEXT && hi == NEXT && used >= NEXT) begin
                    r.st = eabf_pkg::ST_FULL;
                end else begin
                    ns = start;
                    nl = {2'b00, len};
                    if (lo != NEXT) begin
                        ns = ext_start[lo];
                        nl = nl + {2'b00, ext_len[lo]};
                    end
                    if (hi != NEXT) nl = nl + {2'b00, ext_len[hi]};
                    if (nl > 18'hFFFF) nl = 18'hFFFF;
                    if (lo != NEXT && hi != NEXT) begin
                        if (lo > hi) begin remove_at(lo); remove_at(hi); end
                        else begin remove_at(hi); remove_at(lo); end
                    end else if (lo != NEXT) remove_at(lo);
                    else if (hi != NEXT) remove_at(hi);
                    insert_sorted(ns, nl[15:0]);
                    sum = {1'b0, total} + {1'b0, len};
                    total = (sum > 17'hFFFF) ? 16'hFFFF : sum[15:0];
                end
            end
            r.free_cnt = total;
            pending.push_back(r);
        endfunction

        function void check_result(eabf_pkg::t_status st, eabf_pkg::t_idx g,
                                   eabf_pkg::t_idx f);
            t_alloc_res e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.st) begin
                $error("status expected %0d actual %0d", e.st, st);
                errors++;
            end
            if (g !== e.granted) begin
                $error("granted_start expected %0d actual %0d", e.granted, g);
                errors++;
            end
            if (f !== e.free_cnt) begin
                $error("free_blocks expected %0d actual %0d", e.free_cnt, f);
                errors++;
            end
        endfunction
    endclass

    logic                 clk, rst_n;
    logic                 in_valid, in_stall, opcode;
    eabf_pkg::t_idx       run_length, run_start;
    logic                 out_valid, out_stall;
    eabf_pkg::t_status    status;
    eabf_pkg::t_idx       granted_start, free_blocks;
    logic                 cfg_valid, cfg_ready;
    eabf_pkg::t_cfg_index cfg_index;
    eabf_pkg::t_idx       cfg_data;

    extent_scoreboard sb;
    int cycles;
    int send_idle, recv_idle;

    extent_allocator_best_fit_coalesce i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_run_length(run_length), .i_run_start(run_start),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_granted_start(granted_start),
        .o_free_blocks(free_blocks),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Random receiver stall, check every accepted result beat
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, granted_start, free_blocks);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one beat, hold it until taken, then drop valid
    task automatic send_request(logic op, eabf_pkg::t_idx len, eabf_pkg::t_idx start);
        while ($urandom_range(99) < send_idle) @(posedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        run_length <= len;
        run_start <= start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(op, len, start);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold until every result is back, then let the block settle
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_cfg(eabf_pkg::t_cfg_index idx, eabf_pkg::t_idx val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly allocate then free back what was granted, with noise
    task automatic random_phase(int n);
        eabf_pkg::t_idx held_s[$];
        eabf_pkg::t_idx held_l[$];
        t_alloc_res e;
        int k, pick;
        eabf_pkg::t_idx len;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 45) begin
                len = ($urandom_range(9) == 0) ? eabf_pkg::t_idx'($urandom)
                                               : eabf_pkg::t_idx'($urandom_range(64));
                send_request(eabf_pkg::OP_ALLOC, len, eabf_pkg::t_idx'($urandom));
                e = sb.pending[$];
                if (e.st == eabf_pkg::ST_OK) begin
                    held_s.push_back(e.granted);
                    held_l.push_back(len);
                end
            end else if (k < 85 && held_s.size() > 0) begin
                pick = $urandom_range(held_s.size() - 1);
                send_request(eabf_pkg::OP_FREE, held_l[pick], held_s[pick]);
                held_s.delete(pick);
                held_l.delete(pick);
            end else begin
                send_request(logic'($urandom_range(1)), eabf_pkg::t_idx'($urandom),
                             eabf_pkg::t_idx'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear_all();
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = eabf_pkg::OP_ALLOC;
        run_length = '0;
        run_start = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = eabf_pkg::CFG_POOL_BASE;
        cfg_data = '0;
        send_idle = 11;
        recv_idle = 53;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pool, zero lengths, extremes
        send_request(eabf_pkg::OP_ALLOC, 16'd1, '0);
        send_request(eabf_pkg::OP_ALLOC, '0, '0);
        send_request(eabf_pkg::OP_FREE, '0, 16'hFFFF);
        wait_drained();
        write_cfg(eabf_pkg::CFG_POOL_BASE, 16'd100);
        write_cfg(eabf_pkg::CFG_POOL_COUNT, 16'd1000);
        send_request(eabf_pkg::OP_ALLOC, 16'd10, '0);
        send_request(eabf_pkg::OP_ALLOC, 16'd2000, '0);
        send_request(eabf_pkg::OP_ALLOC, 16'd990, '0);
        send_request(eabf_pkg::OP_FREE, 16'd10, 16'd100);
        send_request(eabf_pkg::OP_FREE, 16'd5, 16'd110);
        send_request(eabf_pkg::OP_FREE, 16'd5, 16'd115);
        send_request(eabf_pkg::OP_FREE, 16'hFFFF, 16'hFFFF);
        // Fill the table with isolated runs, then a lone free hits the full case
        for (int i = 0; i < 17; i++)
            send_request(eabf_pkg::OP_FREE, 16'd1, eabf_pkg::t_idx'(20000 + 4 * i));
        send_request(eabf_pkg::OP_FREE, 16'd1, 16'd20002);
        wait_drained();

        // Extremes of the pool registers
        write_cfg(eabf_pkg::CFG_POOL_BASE, 16'hFFFF);
        write_cfg(eabf_pkg::CFG_POOL_COUNT, 16'hFFFF);
        send_request(eabf_pkg::OP_ALLOC, 16'hFFFF, '0);
        send_request(eabf_pkg::OP_FREE, 16'h7FFF, 16'h0000);
        wait_drained();
        write_cfg(eabf_pkg::CFG_POOL_BASE, '0);
        write_cfg(eabf_pkg::CFG_POOL_COUNT, 16'd4096);
        random_phase(400);
        wait_drained();

        send_idle = 53;
        recv_idle = 11;
        write_cfg(eabf_pkg::CFG_POOL_BASE, 16'd512);
        write_cfg(eabf_pkg::CFG_POOL_COUNT, 16'd600);
        random_phase(400);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        write_cfg(eabf_pkg::CFG_POOL_COUNT, 16'd300);
        write_cfg(eabf_pkg::CFG_POOL_BASE, 16'hFE00);
        random_phase(400);
        wait_drained();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/eabf_pkg.sv
sv/eabf_ctrl.sv
sv/eabf_dp.sv
sv/extent_allocator_best_fit_coalesce.sv
tb/extent_allocator_best_fit_coalesce_tb.sv
